// ----- design/htcc_pkg.sv -----
// ----------------------------------------------------------------------------
// htcc_pkg: shared definitions for the calibrated humidity/temperature block
// Widths, pipeline depth, register indexes, clamp limits and the payload
// carried through the divider cell chain.
// ----------------------------------------------------------------------------
package htcc_pkg;

    // Fraction bits of the fixed-point results.
    localparam int FRAC_BITS = 6;
    localparam int ONE       = 1 << FRAC_BITS;

    // Field widths.
    localparam int RAW_W  = 16;
    localparam int OUT_W  = 14;
    localparam int IDX_W  = 4;
    localparam int DATA_W = 16;

    // Scaled calibration output, its difference, raw differences.
    localparam int YW  = FRAC_BITS + 8;
    localparam int DYW = YW + 1;
    localparam int DXW = RAW_W + 1;
    // Signed product, product magnitude, interpolated value.
    localparam int PPW = DYW + DXW;
    localparam int PW  = FRAC_BITS + 24;
    localparam int QW  = PW + 2;

    // Lane stages: difference, multiply, magnitude, then one cell per bit.
    localparam int LN = PW + 3;
    // Whole pipeline: lane stages plus the clamp/output register.
    localparam int NS = LN + 1;

    // Register indexes.
    localparam logic [IDX_W-1:0] REG_HUM_CAL_LO  = 4'd0;
    localparam logic [IDX_W-1:0] REG_HUM_CAL_HI  = 4'd1;
    localparam logic [IDX_W-1:0] REG_TEMP_CAL_LO = 4'd2;
    localparam logic [IDX_W-1:0] REG_TEMP_CAL_HI = 4'd3;
    localparam logic [IDX_W-1:0] REG_HUM_RAW_LO  = 4'd4;
    localparam logic [IDX_W-1:0] REG_HUM_RAW_HI  = 4'd5;
    localparam logic [IDX_W-1:0] REG_TEMP_RAW_LO = 4'd6;
    localparam logic [IDX_W-1:0] REG_TEMP_RAW_HI = 4'd7;

    typedef logic signed [QW-1:0] t_q;

    // Clamp limits in fixed point.
    localparam t_q HUM_TOP     = t_q'(100 * ONE);
    localparam t_q HUM_HOLE_LO = t_q'(-73 * ONE);
    localparam t_q HUM_HOLE_HI = t_q'(-72 * ONE);
    localparam t_q HUM_NEG     = t_q'(-ONE);
    localparam t_q TEMP_TOP    = t_q'(120 * ONE);
    localparam t_q TEMP_BOT    = t_q'(-41 * ONE);
    localparam t_q TEMP_FLOOR  = t_q'(-40 * ONE);

    // Payload handed from one divider cell to the next.
    typedef struct packed {
        logic [DXW-1:0] rem;
        logic [PW-1:0]  num;
        logic [DXW-1:0] dvs;
        logic           neg;
        logic           fault;
        logic [YW-1:0]  y0;
    } t_div;

endpackage

// ----- design/htcc_in_if.sv -----
// ----------------------------------------------------------------------------
// htcc_in_if: raw sample channel
// Carries one humidity/temperature raw pair per transaction.
// ----------------------------------------------------------------------------
interface htcc_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [htcc_pkg::RAW_W-1:0]    raw_humidity;
    logic signed [htcc_pkg::RAW_W-1:0]    raw_temperature;

    modport source(output valid, output raw_humidity, output raw_temperature, input ready);
    modport sink(input valid, input raw_humidity, input raw_temperature, output ready);
endinterface

// ----- design/htcc_out_if.sv -----
// ----------------------------------------------------------------------------
// htcc_out_if: converted result channel
// Carries calibrated temperature and humidity with the fault flags.
// ----------------------------------------------------------------------------
interface htcc_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [htcc_pkg::OUT_W-1:0]    temperature_q6;
    logic signed [htcc_pkg::OUT_W-1:0]    humidity_q6;
    logic                                 temp_cal_fault;
    logic                                 hum_cal_fault;

    modport source(output valid, output temperature_q6, output humidity_q6,
                   output temp_cal_fault, output hum_cal_fault, input ready);
    modport sink(input valid, input temperature_q6, input humidity_q6,
                 input temp_cal_fault, input hum_cal_fault, output ready);
endinterface

// ----- design/htcc_cfg_if.sv -----
// ----------------------------------------------------------------------------
// htcc_cfg_if: configuration write channel
// Carries a register index and write data per transaction.
// ----------------------------------------------------------------------------
interface htcc_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [htcc_pkg::IDX_W-1:0]       index;
    logic [htcc_pkg::DATA_W-1:0]      data;

    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

// ----- design/htcc_div_cell.sv -----
// ----------------------------------------------------------------------------
// htcc_div_cell: one restoring division cell
// Shifts in one dividend bit, subtracts the divisor when it fits and hands
// the updated remainder and quotient to the next cell.
// ----------------------------------------------------------------------------
module htcc_div_cell (
    input  logic             i_clk,
    input  logic             i_en,
    input  htcc_pkg::t_div   i_d,
    output htcc_pkg::t_div   o_d
);

    htcc_pkg::t_div         r_d;
    htcc_pkg::t_div         n_d;
    logic [htcc_pkg::DXW:0] trial;
    logic                   fits;

    // Trial subtraction of the divisor from the shifted remainder.
    always_comb begin
        trial = {i_d.rem, i_d.num[htcc_pkg::PW-1]};
        fits  = (trial >= {1'b0, i_d.dvs});
        n_d   = i_d;
        n_d.num = {i_d.num[htcc_pkg::PW-2:0], fits};
        if (fits) begin
            n_d.rem = htcc_pkg::DXW'(trial - {1'b0, i_d.dvs});
        end else begin
            n_d.rem = trial[htcc_pkg::DXW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

// ----- design/htcc_lane.sv -----
// ----------------------------------------------------------------------------
// htcc_lane: one interpolation lane
// Forms the differences, the product and its magnitude, then divides through
// a chain of cells and applies the sign and the lower calibration output.
// ----------------------------------------------------------------------------
module htcc_lane (
    input  logic                                 i_clk,
    input  logic [htcc_pkg::LN-1:0]              i_en,
    input  logic signed [htcc_pkg::RAW_W-1:0]    i_x,
    input  logic signed [htcc_pkg::RAW_W-1:0]    i_x0,
    input  logic signed [htcc_pkg::RAW_W-1:0]    i_x1,
    input  logic [htcc_pkg::YW-1:0]              i_y0,
    input  logic [htcc_pkg::YW-1:0]              i_y1,
    output htcc_pkg::t_q                         o_q,
    output logic                                 o_fault
);

    logic signed [htcc_pkg::DYW-1:0] r_dy;
    logic signed [htcc_pkg::DXW-1:0] r_dxm;
    logic signed [htcc_pkg::DXW-1:0] r_dx_a;
    logic [htcc_pkg::YW-1:0]         r_y0_a;
    logic signed [htcc_pkg::PPW-1:0] r_p;
    logic signed [htcc_pkg::DXW-1:0] r_dx_b;
    logic [htcc_pkg::YW-1:0]         r_y0_b;
    htcc_pkg::t_div                  r_c0;
    htcc_pkg::t_div                  n_c0;
    htcc_pkg::t_div                  chain [htcc_pkg::PW+1];
    logic signed [htcc_pkg::PPW-1:0] p_abs;
    logic signed [htcc_pkg::DXW-1:0] dx_abs;
    htcc_pkg::t_q                    quot;

    // Differences against the lower calibration point.
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_dy   <= htcc_pkg::DYW'($signed({1'b0, i_y1})) - htcc_pkg::DYW'($signed({1'b0, i_y0}));
            r_dxm  <= htcc_pkg::DXW'(i_x) - htcc_pkg::DXW'(i_x0);
            r_dx_a <= htcc_pkg::DXW'(i_x1) - htcc_pkg::DXW'(i_x0);
            r_y0_a <= i_y0;
        end
    end

    // Product before the division.
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_p    <= htcc_pkg::PPW'(r_dy) * htcc_pkg::PPW'(r_dxm);
            r_dx_b <= r_dx_a;
            r_y0_b <= r_y0_a;
        end
    end

    // Magnitudes and result sign enter the divider chain.
    always_comb begin
        p_abs  = r_p[htcc_pkg::PPW-1] ? -r_p : r_p;
        dx_abs = r_dx_b[htcc_pkg::DXW-1] ? -r_dx_b : r_dx_b;
        n_c0.rem   = '0;
        n_c0.num   = p_abs[htcc_pkg::PW-1:0];
        n_c0.dvs   = dx_abs;
        n_c0.neg   = r_p[htcc_pkg::PPW-1] ^ r_dx_b[htcc_pkg::DXW-1];
        n_c0.fault = (r_dx_b == '0);
        n_c0.y0    = r_y0_b;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_c0 <= n_c0;
        end
    end

    assign chain[0] = r_c0;

    // One quotient bit per cell, most significant first.
    for (genvar k = 0; k < htcc_pkg::PW; k++) begin : g_cell
        htcc_div_cell u_cell (
            .i_clk (i_clk),
            .i_en  (i_en[k+3]),
            .i_d   (chain[k]),
            .o_d   (chain[k+1])
        );
    end

    // Apply the sign and add the lower calibration output.
    always_comb begin
        quot = $signed({2'b00, chain[htcc_pkg::PW].num});
        if (chain[htcc_pkg::PW].fault) begin
            o_q = '0;
        end else if (chain[htcc_pkg::PW].neg) begin
            o_q = $signed(htcc_pkg::QW'(chain[htcc_pkg::PW].y0)) - quot;
        end else begin
            o_q = $signed(htcc_pkg::QW'(chain[htcc_pkg::PW].y0)) + quot;
        end
    end

    assign o_fault = chain[htcc_pkg::PW].fault;

endmodule

// ----- design/humidity_temp_calibrated_conversion_top.sv -----
// ----------------------------------------------------------------------------
// Throughput: one sample pair per cycle while the output is not stalled; each
// divider cell retires one quotient bit, so the cell chain length sets the
// latency, not the rate.
// A stall at the output register reaches back combinationally through every full stage.
// Reset clears the calibration registers to zero and empties the pipeline.
// ----------------------------------------------------------------------------
// humidity_temp_calibrated_conversion_top: calibrated sensor conversion
// Two-point linear interpolation of raw humidity and temperature with
// clamping and calibration fault flags.
// ----------------------------------------------------------------------------
module humidity_temp_calibrated_conversion_top (
    input  logic     i_clk,
    input  logic     i_rst_n,
    htcc_in_if.sink  i_in,
    htcc_out_if.source o_out,
    htcc_cfg_if.sink i_cfg
);

    logic [7:0]                       r_hum_cal_lo;
    logic [7:0]                       r_hum_cal_hi;
    logic [9:0]                       r_temp_cal_lo;
    logic [9:0]                       r_temp_cal_hi;
    logic signed [htcc_pkg::RAW_W-1:0] r_hum_raw_lo;
    logic signed [htcc_pkg::RAW_W-1:0] r_hum_raw_hi;
    logic signed [htcc_pkg::RAW_W-1:0] r_temp_raw_lo;
    logic signed [htcc_pkg::RAW_W-1:0] r_temp_raw_hi;

    logic [htcc_pkg::NS-1:0]          r_v;
    logic [htcc_pkg::NS-1:0]          adv;
    logic                             accept;

    htcc_pkg::t_q                     hum_q;
    htcc_pkg::t_q                     temp_q;
    logic                             hum_fault;
    logic                             temp_fault;
    htcc_pkg::t_q                     n_hum;
    htcc_pkg::t_q                     n_temp;
    logic signed [htcc_pkg::OUT_W-1:0] r_hum_out;
    logic signed [htcc_pkg::OUT_W-1:0] r_temp_out;
    logic                             r_hum_fault;
    logic                             r_temp_fault;

    // Configuration registers; writes are always taken.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hum_cal_lo  <= '0;
            r_hum_cal_hi  <= '0;
            r_temp_cal_lo <= '0;
            r_temp_cal_hi <= '0;
            r_hum_raw_lo  <= '0;
            r_hum_raw_hi  <= '0;
            r_temp_raw_lo <= '0;
            r_temp_raw_hi <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                htcc_pkg::REG_HUM_CAL_LO:  r_hum_cal_lo  <= i_cfg.data[7:0];
                htcc_pkg::REG_HUM_CAL_HI:  r_hum_cal_hi  <= i_cfg.data[7:0];
                htcc_pkg::REG_TEMP_CAL_LO: r_temp_cal_lo <= i_cfg.data[9:0];
                htcc_pkg::REG_TEMP_CAL_HI: r_temp_cal_hi <= i_cfg.data[9:0];
                htcc_pkg::REG_HUM_RAW_LO:  r_hum_raw_lo  <= i_cfg.data;
                htcc_pkg::REG_HUM_RAW_HI:  r_hum_raw_hi  <= i_cfg.data;
                htcc_pkg::REG_TEMP_RAW_LO: r_temp_raw_lo <= i_cfg.data;
                htcc_pkg::REG_TEMP_RAW_HI: r_temp_raw_hi <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // A stage advances when it is empty or the stage after it advances.
    always_comb begin
        adv[htcc_pkg::NS-1] = !r_v[htcc_pkg::NS-1] || o_out.ready;
        for (int k = htcc_pkg::NS - 2; k >= 0; k--) begin
            adv[k] = !r_v[k] || adv[k+1];
        end
    end

    assign i_in.ready = adv[0];
    assign accept     = i_in.valid && adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < htcc_pkg::NS; k++) begin
                if (adv[k]) begin
                    r_v[k] <= (k == 0) ? accept : r_v[k-1];
                end
            end
        end
    end

    // Humidity lane: calibration points in half percent.
    htcc_lane u_hum (
        .i_clk   (i_clk),
        .i_en    (adv[htcc_pkg::LN-1:0]),
        .i_x     (i_in.raw_humidity),
        .i_x0    (r_hum_raw_lo),
        .i_x1    (r_hum_raw_hi),
        .i_y0    (htcc_pkg::YW'(r_hum_cal_lo) << (htcc_pkg::FRAC_BITS - 1)),
        .i_y1    (htcc_pkg::YW'(r_hum_cal_hi) << (htcc_pkg::FRAC_BITS - 1)),
        .o_q     (hum_q),
        .o_fault (hum_fault)
    );

    // Temperature lane: calibration points in eighth degrees.
    htcc_lane u_temp (
        .i_clk   (i_clk),
        .i_en    (adv[htcc_pkg::LN-1:0]),
        .i_x     (i_in.raw_temperature),
        .i_x0    (r_temp_raw_lo),
        .i_x1    (r_temp_raw_hi),
        .i_y0    (htcc_pkg::YW'(r_temp_cal_lo) << (htcc_pkg::FRAC_BITS - 3)),
        .i_y1    (htcc_pkg::YW'(r_temp_cal_hi) << (htcc_pkg::FRAC_BITS - 3)),
        .o_q     (temp_q),
        .o_fault (temp_fault)
    );

    // Clamps, judged on the integer part truncated toward zero.
    always_comb begin
        priority if (hum_q >= htcc_pkg::HUM_TOP ||
                     (hum_q > htcc_pkg::HUM_HOLE_LO && hum_q <= htcc_pkg::HUM_HOLE_HI)) begin
            n_hum = htcc_pkg::HUM_TOP;
        end else if (hum_q <= htcc_pkg::HUM_NEG) begin
            n_hum = '0;
        end else begin
            n_hum = hum_q;
        end
        priority if (temp_q >= htcc_pkg::TEMP_TOP) begin
            n_temp = htcc_pkg::TEMP_TOP;
        end else if (temp_q <= htcc_pkg::TEMP_BOT) begin
            n_temp = htcc_pkg::TEMP_FLOOR;
        end else begin
            n_temp = temp_q;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (adv[htcc_pkg::NS-1]) begin
            r_hum_out    <= n_hum[htcc_pkg::OUT_W-1:0];
            r_temp_out   <= n_temp[htcc_pkg::OUT_W-1:0];
            r_hum_fault  <= hum_fault;
            r_temp_fault <= temp_fault;
        end
    end

    assign o_out.valid          = r_v[htcc_pkg::NS-1];
    assign o_out.temperature_q6 = r_temp_out;
    assign o_out.humidity_q6    = r_hum_out;
    assign o_out.temp_cal_fault = r_temp_fault;
    assign o_out.hum_cal_fault  = r_hum_fault;

endmodule
